// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by software_timer_bank
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define STB_ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define STB_ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

// ===== rtl/stb_pkg.sv =====
// ----------------------------------------------------------------------------
// stb_pkg
// types and constants of the software timer bank
// ----------------------------------------------------------------------------
`default_nettype none

package stb_pkg;

   localparam int CmdWidth   = 2;
   localparam int IndexWidth = 3;
   localparam int CountWidth = 16;
   localparam int MapWidth   = 8;

   typedef enum logic [CmdWidth-1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic [CountWidth-1:0] limit;
      logic [CountWidth-1:0] elapsed;
      logic [CountWidth-1:0] total;
   } entry_type;

   typedef struct packed {
      logic enable;
      logic expired;
      logic write;
   } flags_type;

endpackage

`default_nettype wire

// ===== rtl/stb_entry_ram.sv =====
// ----------------------------------------------------------------------------
// stb_entry_ram
// per-timer entry store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module stb_entry_ram #(
   parameter int Depth     = 8,
   parameter int AddrWidth = 3
) (
   input  wire logic                  clock,
   input  wire logic                  rd_en,
   input  wire logic [AddrWidth-1:0]  rd_addr,
   output      stb_pkg::entry_type    rd_data,
   input  wire logic                  wr_en,
   input  wire logic [AddrWidth-1:0]  wr_addr,
   input       stb_pkg::entry_type    wr_data
);
   import stb_pkg::*;

   entry_type mem [Depth];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/stb_update.sv =====
// ----------------------------------------------------------------------------
// stb_update
// next entry and flags of one timer for start, stop, tick and read
// ----------------------------------------------------------------------------
`default_nettype none

module stb_update (
   input       stb_pkg::cmd_type                    op,
   input  wire logic                                in_range,
   input  wire logic [stb_pkg::CountWidth-1:0]      preset,
   input  wire logic                                enabled,
   input  wire logic                                expired,
   input       stb_pkg::entry_type                  cur,
   output      stb_pkg::entry_type                  nxt,
   output      stb_pkg::flags_type                  flg
);
   import stb_pkg::*;

   always_comb begin
      nxt         = cur;
      flg.enable  = enabled;
      flg.expired = expired;
      flg.write   = 1'b0;
      unique case (op)
         CMD_START: begin
            if (in_range && !enabled) begin
               nxt.limit   = (preset == '0) ? '0 : preset - 1'b1;
               nxt.elapsed = '0;
               flg.enable  = 1'b1;
               flg.expired = 1'b0;
               flg.write   = 1'b1;
            end
         end
         CMD_STOP: begin
            if (in_range) begin
               nxt.limit   = '0;
               nxt.elapsed = '0;
               flg.enable  = 1'b0;
               flg.expired = 1'b0;
               flg.write   = 1'b1;
            end
         end
         CMD_TICK: begin
            if (enabled) begin
               flg.write = 1'b1;
               if (cur.elapsed >= cur.limit) begin
                  nxt.elapsed = '0;
                  nxt.total   = cur.total + 1'b1;
                  flg.expired = 1'b1;
               end else begin
                  nxt.elapsed = cur.elapsed + 1'b1;
               end
            end
         end
         CMD_READ: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/software_timer_bank.sv =====
// ----------------------------------------------------------------------------
// software_timer_bank
// bank of TIMER_COUNT software timers kept in an entry memory
// ----------------------------------------------------------------------------
// Usage: one item on the req_ channel (command, timer index, preset) yields
// one item on the rsp_ channel with the addressed timer's state after the
// command and the bitmap of expired flags of timers 0 to 7.
// Start, stop and read pass through one memory read of the addressed entry
// in the lookup state and one read-modify-write in the update state.
// Tick first sweeps the timers: the sweep reads entry i while writing
// back entry i-1, then the addressed entry is read for the report.
// One item is in work at a time; req_ready is high while the sequencer is
// idle, also while an earlier result still waits in the output register.
// If the receiver stalls, a finished item waits in the sequencer until the
// output register is free, and nothing in the bank changes meanwhile.
// Reset clears all timers at once through per-entry valid bits; the entry
// memory needs no clearing pass and the first item may follow reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module software_timer_bank #(
   parameter int TIMER_COUNT = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire logic [stb_pkg::CmdWidth-1:0]       req_cmd,
   input  wire logic [stb_pkg::IndexWidth-1:0]     req_timer_index,
   input  wire logic [stb_pkg::CountWidth-1:0]     req_preset,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      logic [stb_pkg::IndexWidth-1:0]     rsp_report_index,
   output      logic                               rsp_running,
   output      logic [stb_pkg::CountWidth-1:0]     rsp_elapsed,
   output      logic                               rsp_expired,
   output      logic [stb_pkg::CountWidth-1:0]     rsp_expiry_total,
   output      logic [stb_pkg::MapWidth-1:0]       rsp_expired_map
);
   import stb_pkg::*;

   localparam int AddrWidth  = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam int SweepWidth = $clog2(TIMER_COUNT + 1);

   state_type                   state_ff, state_in;
   logic [SweepWidth-1:0]       sweep_ff, sweep_in;
   cmd_type                     cmd_ff;
   logic [IndexWidth-1:0]       idx_ff;
   logic [CountWidth-1:0]       preset_ff;

   logic [TIMER_COUNT-1:0]      enable_ff, enable_in;
   logic [TIMER_COUNT-1:0]      expired_ff, expired_in;
   logic [TIMER_COUNT-1:0]      written_ff, written_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [IndexWidth-1:0]       rsp_index_ff;
   logic                        rsp_running_ff, rsp_running_in;
   logic [CountWidth-1:0]       rsp_elapsed_ff, rsp_elapsed_in;
   logic                        rsp_expired_ff, rsp_expired_in;
   logic [CountWidth-1:0]       rsp_total_ff, rsp_total_in;
   logic [MapWidth-1:0]         rsp_map_ff, rsp_map_in;

   logic [AddrWidth+IndexWidth-1:0] idx_ext;
   logic [AddrWidth-1:0]        idx_addr;
   logic                        idx_ok;
   logic [AddrWidth-1:0]        sweep_addr;
   logic [AddrWidth-1:0]        prev_addr;
   logic                        sweep_last;
   logic                        sweep_write;
   logic                        rsp_free;
   logic                        do_update;

   logic                        mem_rd_en;
   logic [AddrWidth-1:0]        mem_rd_addr;
   entry_type                   mem_rd_data;
   logic                        mem_wr_en;

   cmd_type                     upd_op;
   logic [AddrWidth-1:0]        upd_addr;
   logic                        upd_in_range;
   logic                        upd_enabled;
   logic                        upd_expired;
   entry_type                   upd_cur;
   entry_type                   upd_nxt;
   flags_type                   upd_flg;

   assign idx_ext     = {{AddrWidth{1'b0}}, idx_ff};
   assign idx_addr    = idx_ext[AddrWidth-1:0];
   assign idx_ok      = 32'(idx_ff) < 32'(TIMER_COUNT);
   assign sweep_addr  = sweep_ff[AddrWidth-1:0];
   assign prev_addr   = sweep_addr - 1'b1;
   assign sweep_last  = sweep_ff == SweepWidth'(TIMER_COUNT);
   assign sweep_write = (state_ff == ST_SWEEP) && (sweep_ff != '0);
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign do_update   = (state_ff == ST_UPDATE) && rsp_free;

   // entry under update: previous sweep slot or the addressed timer
   always_comb begin
      if (state_ff == ST_SWEEP) begin
         upd_op       = CMD_TICK;
         upd_addr     = prev_addr;
         upd_in_range = 1'b1;
      end else begin
         upd_op       = (cmd_ff == CMD_TICK) ? CMD_READ : cmd_ff;
         upd_addr     = idx_addr;
         upd_in_range = idx_ok;
      end
   end

   assign upd_enabled = upd_in_range && enable_ff[upd_addr];
   assign upd_expired = upd_in_range && expired_ff[upd_addr];
   assign upd_cur     = (upd_in_range && written_ff[upd_addr]) ? mem_rd_data : '0;

   stb_update u_update (
      .op       (upd_op),
      .in_range (upd_in_range),
      .preset   (preset_ff),
      .enabled  (upd_enabled),
      .expired  (upd_expired),
      .cur      (upd_cur),
      .nxt      (upd_nxt),
      .flg      (upd_flg)
   );

   assign mem_rd_en   = ((state_ff == ST_SWEEP) && !sweep_last) || (state_ff == ST_LOOKUP);
   assign mem_rd_addr = (state_ff == ST_SWEEP) ? sweep_addr : idx_addr;
   assign mem_wr_en   = (sweep_write || do_update) && upd_flg.write;

   stb_entry_ram #(
      .Depth     (TIMER_COUNT),
      .AddrWidth (AddrWidth)
   ) u_entry_ram (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (upd_addr),
      .wr_data (upd_nxt)
   );

   always_comb begin
      enable_in  = enable_ff;
      expired_in = expired_ff;
      written_in = written_ff;
      if (mem_wr_en) begin
         enable_in[upd_addr]  = upd_flg.enable;
         expired_in[upd_addr] = upd_flg.expired;
         written_in[upd_addr] = 1'b1;
      end
   end

   for (genvar i = 0; i < MapWidth; i++) begin : g_map
      if (i < TIMER_COUNT) begin : g_live
         assign rsp_map_in[i] = expired_in[i];
      end else begin : g_none
         assign rsp_map_in[i] = 1'b0;
      end
   end

   assign rsp_running_in = upd_in_range && upd_flg.enable;
   assign rsp_elapsed_in = upd_in_range ? upd_nxt.elapsed : '0;
   assign rsp_expired_in = upd_in_range && upd_flg.expired;
   assign rsp_total_in   = upd_in_range ? upd_nxt.total : '0;

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            sweep_in  = '0;
            if (req_valid) begin
               state_in = (cmd_type'(req_cmd) == CMD_TICK) ? ST_SWEEP : ST_LOOKUP;
            end
         end
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = ST_LOOKUP;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (rsp_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sweep_ff     <= '0;
         enable_ff    <= '0;
         expired_ff   <= '0;
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         enable_ff    <= enable_in;
         expired_ff   <= expired_in;
         written_ff   <= written_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff    <= cmd_type'(req_cmd);
         idx_ff    <= req_timer_index;
         preset_ff <= req_preset;
      end
      if (do_update) begin
         rsp_index_ff   <= idx_ff;
         rsp_running_ff <= rsp_running_in;
         rsp_elapsed_ff <= rsp_elapsed_in;
         rsp_expired_ff <= rsp_expired_in;
         rsp_total_ff   <= rsp_total_in;
         rsp_map_ff     <= rsp_map_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_report_index = rsp_index_ff;
   assign rsp_running      = rsp_running_ff;
   assign rsp_elapsed      = rsp_elapsed_ff;
   assign rsp_expired      = rsp_expired_ff;
   assign rsp_expiry_total = rsp_total_ff;
   assign rsp_expired_map  = rsp_map_ff;

   `STB_ASSERT_HOLDS(a_flags_need_entry, clock, reset, ((enable_ff | expired_ff) & ~written_ff) == '0, "timer flag set on an entry never written")
   `STB_ASSERT_IMPLIES(a_write_when_busy, clock, reset, mem_wr_en, (state_ff == ST_SWEEP) || (state_ff == ST_UPDATE), "entry write outside sweep or update")
   `STB_ASSERT_IMPLIES(a_rsp_from_update, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_UPDATE), "result item loaded outside update")
   `STB_ASSERT_IMPLIES(a_sweep_bound, clock, reset, state_ff == ST_SWEEP, sweep_ff <= SweepWidth'(TIMER_COUNT), "sweep ran past the last timer")

endmodule

`default_nettype wire
